// ----- hw/rtl/temperature_trend_tracker_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Temperature trend tracker assertion macros
// Concurrent check wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_TREND_TRACKER_UNIT_ASSERT_SVH
`define TEMPERATURE_TREND_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TTT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("temperature trend tracker check failed");
// condition must never be seen out of reset
`define TTT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("temperature trend tracker forbidden condition");
`else
`define TTT_ASSERT(lbl, clk, rstn, prop)
`define TTT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- hw/rtl/ttt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and constants of the temperature trend tracker.
// ----------------------------------------------------------------------------
package ttt_pkg;

  // configuration port
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 16;
  localparam int unsigned SmoothBits    = 16;
  localparam int unsigned ThreshBits    = 15;
  localparam int unsigned SmoothShift   = 16;  // factor is Q0.16
  localparam int unsigned TrendBits     = 2;

  localparam logic [SmoothBits-1:0] SmoothReset = 16'd6554;
  localparam logic [ThreshBits-1:0] ThreshReset = 15'd32;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CFG_SMOOTHING_FACTOR = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_TREND_THRESHOLD  = 2'd1;

  typedef enum logic [TrendBits-1:0] {
    TREND_NONE    = 2'd0,
    TREND_RISING  = 2'd1,
    TREND_FALLING = 2'd2
  } trend_e;

  typedef struct packed {
    logic [SmoothBits-1:0] smoothing_factor;
    logic [ThreshBits-1:0] trend_threshold;
  } cfg_t;

endpackage

// ----- hw/rtl/temperature_trend_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// temperature_trend_tracker_unit
// Stages: input register, single-pass update logic, result register.
// Throughput: one word per cycle while the receiver does not stall.
// The average/trend state loop is fed back combinationally from the filter state.
// Reset: async active low; clears state, empties both stages, loads
// register defaults (factor 6554, threshold 32). No clearing pass.
// ----------------------------------------------------------------------------
`include "temperature_trend_tracker_unit_assert.svh"

module temperature_trend_tracker_unit #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [ttt_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ttt_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  // sample input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    temp_sample_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    session_min_o,
  output logic signed [SAMPLE_BITS-1:0]    session_max_o,
  output logic signed [SAMPLE_BITS-1:0]    smoothed_temp_o,
  output logic [ttt_pkg::TrendBits-1:0]    trend_o
);
  import ttt_pkg::*;

  cfg_t                          cfg;
  logic                          in_vld_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          out_vld_q;
  logic                          out_free;
  logic                          adv;
  logic                          in_take;
  logic signed [SAMPLE_BITS-1:0] min_w, max_w, avg_w;
  logic [TrendBits-1:0]          trend_w;
  logic signed [SAMPLE_BITS-1:0] min_q, max_q, avg_q;
  logic [TrendBits-1:0]          trend_q;

  ttt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // stage handshake: input word moves to the result register when it is free
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take)       in_vld_q <= 1'b1;
      else if (adv)      in_vld_q <= 1'b0;
      if (adv)           out_vld_q <= 1'b1;
      else if (out_free) out_vld_q <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) sample_q <= temp_sample_i;
  end

  ttt_filter #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .upd_i    (adv),
    .sample_i (sample_q),
    .min_o    (min_w),
    .max_o    (max_w),
    .avg_o    (avg_w),
    .trend_o  (trend_w)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      min_q   <= min_w;
      max_q   <= max_w;
      avg_q   <= avg_w;
      trend_q <= trend_w;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign session_min_o   = min_q;
  assign session_max_o   = max_q;
  assign smoothed_temp_o = avg_q;
  assign trend_o         = trend_q;

  // checks
  `TTT_ASSERT(a_min_le_max, clk_i, rst_ni, out_valid_o |-> session_min_o <= session_max_o)
  `TTT_ASSERT(a_avg_in_range, clk_i, rst_ni, out_valid_o |->
              (smoothed_temp_o >= session_min_o && smoothed_temp_o <= session_max_o))
  `TTT_ASSERT(a_take_fills, clk_i, rst_ni, in_take |=> in_vld_q)
  `TTT_ASSERT_NEVER(a_no_drop, clk_i, rst_ni, in_take && in_vld_q && !adv)

endmodule

// ----- hw/rtl/ttt_cfg.sv -----
// ----------------------------------------------------------------------------
// ttt_cfg
// Configuration register bank: smoothing factor and trend threshold.
// ----------------------------------------------------------------------------
module ttt_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ttt_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ttt_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  output ttt_pkg::cfg_t                    cfg_o
);
  import ttt_pkg::*;

  cfg_t cfg_q, cfg_d;

  // index decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SMOOTHING_FACTOR: cfg_d.smoothing_factor = cfg_wdata_i[SmoothBits-1:0];
        CFG_TREND_THRESHOLD:  cfg_d.trend_threshold  = cfg_wdata_i[ThreshBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smoothing_factor <= SmoothReset;
      cfg_q.trend_threshold  <= ThreshReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/ttt_filter.sv -----
// ----------------------------------------------------------------------------
// ttt_filter
// Session min/max, moving average and trend state with its update datapath.
// ----------------------------------------------------------------------------
module ttt_filter #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ttt_pkg::cfg_t                   cfg_i,
  input  logic                            upd_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  output logic signed [SAMPLE_BITS-1:0]   min_o,
  output logic signed [SAMPLE_BITS-1:0]   max_o,
  output logic signed [SAMPLE_BITS-1:0]   avg_o,
  output logic [ttt_pkg::TrendBits-1:0]   trend_o
);
  import ttt_pkg::*;

  localparam int unsigned AccBits  = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned DiffBits = AccBits + 1;
  localparam int unsigned ProdBits = DiffBits + SmoothBits + 1;
  localparam int unsigned WideBits = ((SAMPLE_BITS > ThreshBits) ? SAMPLE_BITS : ThreshBits)
                                     + FRACTION_BITS + 2;

  logic                          have_q, have_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic signed [AccBits-1:0]     avg_q, avg_d, ref_q, ref_d;

  logic signed [AccBits-1:0]     sample_acc;
  logic signed [DiffBits-1:0]    diff;
  logic signed [ProdBits-1:0]    prod;
  logic signed [AccBits-1:0]     avg_step;
  logic signed [AccBits-1:0]     avg_upd;
  logic signed [WideBits-1:0]    ref_gap;
  logic signed [WideBits-1:0]    thresh;
  logic                          rising, falling;
  trend_e                        trend;

  // average step: floor(diff * factor / 2^16)
  assign sample_acc = {sample_i, {FRACTION_BITS{1'b0}}};
  assign diff       = DiffBits'(sample_acc) - DiffBits'(avg_q);
  assign prod       = ProdBits'(diff) * $signed({1'b0, cfg_i.smoothing_factor});
  assign avg_step   = prod[SmoothShift +: AccBits];
  assign avg_upd    = avg_q + avg_step;

  // distance of the new average from the reference
  assign ref_gap = WideBits'(avg_upd) - WideBits'(ref_q);
  assign thresh  = $signed({{(WideBits-ThreshBits-FRACTION_BITS){1'b0}},
                            cfg_i.trend_threshold, {FRACTION_BITS{1'b0}}});
  assign rising  = ref_gap >= thresh;
  assign falling = ref_gap <= -thresh;

  // next state and result
  always_comb begin
    have_d = 1'b1;
    min_d  = min_q;
    max_d  = max_q;
    avg_d  = avg_q;
    ref_d  = ref_q;
    trend  = TREND_NONE;
    if (!have_q) begin
      min_d = sample_i;
      max_d = sample_i;
      avg_d = sample_acc;
      ref_d = sample_acc;
    end else begin
      if (sample_i < min_q) min_d = sample_i;
      if (sample_i > max_q) max_d = sample_i;
      avg_d = avg_upd;
      if (rising) begin
        trend = TREND_RISING;
      end else if (falling) begin
        trend = TREND_FALLING;
      end else begin
        ref_d = avg_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      min_q  <= '0;
      max_q  <= '0;
      avg_q  <= '0;
      ref_q  <= '0;
    end else if (upd_i) begin
      have_q <= have_d;
      min_q  <= min_d;
      max_q  <= max_d;
      avg_q  <= avg_d;
      ref_q  <= ref_d;
    end
  end

  // floor of the average to whole sample units
  assign min_o   = min_d;
  assign max_o   = max_d;
  assign avg_o   = avg_d[FRACTION_BITS +: SAMPLE_BITS];
  assign trend_o = trend;

endmodule

// ----- tb/temperature_trend_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_trend_checker
// Watches the configuration port and both word channels of the temperature
// trend tracker. It tracks the min/max, moving average and trend reference
// for every accepted sample and compares each result word against the
// oldest predicted reading.
// ----------------------------------------------------------------------------
module temperature_trend_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration port, observed
  input  logic                             cfg_we_i,
  input  logic [ttt_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ttt_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  // sample channel, observed
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic signed [15:0]               temp_sample_i,
  // result channel, observed
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [15:0]               session_min_i,
  input  logic signed [15:0]               session_max_i,
  input  logic signed [15:0]               smoothed_temp_i,
  input  logic [ttt_pkg::TrendBits-1:0]    trend_i,
  // status toward the testbench top
  output int                               pending_o,
  output int                               mismatches_o
);
  import ttt_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic signed [15:0] smooth;
    trend_e             trend;
  } reading_t;

  // tracker copy: configuration and state
  logic [SmoothBits-1:0] factor_q;
  logic [ThreshBits-1:0] thresh_q;
  bit                    seen_q;
  logic signed [15:0]    min_q;
  logic signed [15:0]    max_q;
  longint                avg_q;
  longint                ref_q;

  reading_t expected_readings[$];
  int       pending_q;
  int       mismatches_q = 0;

  assign pending_o    = pending_q;
  assign mismatches_o = mismatches_q;

  // advance the tracker by one sample and queue the reading it gives
  task automatic track_sample(input logic signed [15:0] s);
    longint   scaled;
    longint   diff;
    longint   err;
    longint   span;
    reading_t r;
    scaled  = longint'(s) <<< FracBits;
    r.trend = TREND_NONE;
    if (!seen_q) begin
      // first sample loads everything, trend stays none
      seen_q = 1'b1;
      min_q  = s;
      max_q  = s;
      avg_q  = scaled;
      ref_q  = scaled;
    end else begin
      if (s < min_q) min_q = s;
      if (s > max_q) max_q = s;
      diff  = scaled - avg_q;
      avg_q = avg_q + ((diff * longint'(factor_q)) >>> SmoothShift);
      err   = avg_q - ref_q;
      span  = longint'(thresh_q) <<< FracBits;
      if (err >= span) begin
        r.trend = TREND_RISING;
      end else if (err <= -span) begin
        r.trend = TREND_FALLING;
      end else begin
        // steady: reference follows the average
        ref_q = avg_q;
      end
    end
    r.low    = min_q;
    r.high   = max_q;
    r.smooth = 16'(avg_q >>> FracBits);
    expected_readings.push_back(r);
  endtask

  // compare one result word with the oldest reading
  task automatic check_reading();
    reading_t r;
    if (expected_readings.size() == 0) begin
      mismatches_q++;
      if (mismatches_q <= MaxReports)
        $display("%0t: unexpected result word: min %0d max %0d avg %0d trend %0d",
                 $realtime, session_min_i, session_max_i, smoothed_temp_i, trend_i);
    end else begin
      r = expected_readings.pop_front();
      if (session_min_i !== r.low || session_max_i !== r.high ||
          smoothed_temp_i !== r.smooth || trend_i !== r.trend) begin
        mismatches_q++;
        if (mismatches_q <= MaxReports)
          $display("%0t: mismatch: min %0d/%0d max %0d/%0d avg %0d/%0d trend %0d/%0d",
                   $realtime, r.low, session_min_i, r.high, session_max_i,
                   r.smooth, smoothed_temp_i, r.trend, trend_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q = SmoothReset;
      thresh_q = ThreshReset;
      seen_q   = 1'b0;
      min_q    = '0;
      max_q    = '0;
      avg_q    = 0;
      ref_q    = 0;
      expected_readings.delete();
      pending_q = 0;
    end else begin
      // register writes; spare indexes are ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SMOOTHING_FACTOR: factor_q = cfg_wdata_i[SmoothBits-1:0];
          CFG_TREND_THRESHOLD:  thresh_q = cfg_wdata_i[ThreshBits-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_reading();
      if (in_valid_i && !in_stall_i) track_sample(temp_sample_i);
      pending_q = expected_readings.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the temperature trend tracker: a directed pass
// over field extremes and register corner settings, then phases of random
// temperature sequences under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import ttt_pkg::*;

  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned EndWait     = 20000;
  localparam logic [CfgIdxBits-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {SEQ_WALK, SEQ_RAMP, SEQ_STEP, SEQ_PLATEAU, SEQ_NOISE} seq_kind_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i     = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i   = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic signed [15:0]     temp_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic signed [15:0]     session_min_o;
  logic signed [15:0]     session_max_o;
  logic signed [15:0]     smoothed_temp_o;
  logic [TrendBits-1:0]   trend_o;

  int pending;
  int mismatches;
  int burst_left = 0;
  int cur_temp   = 0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  always #2 clk_i = ~clk_i;

  temperature_trend_tracker_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .temp_sample_i  (temp_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .session_min_o  (session_min_o),
    .session_max_o  (session_max_o),
    .smoothed_temp_o(smoothed_temp_o),
    .trend_o        (trend_o)
  );

  temperature_trend_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .temp_sample_i  (temp_sample_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .session_min_i  (session_min_o),
    .session_max_i  (session_max_o),
    .smoothed_temp_i(smoothed_temp_o),
    .trend_i        (trend_o),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  // offer one sample word, hold it until taken; bursts end in random gaps
  task automatic send_sample(input logic signed [15:0] v);
    int gap;
    in_valid_i    <= 1'b1;
    temp_sample_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // quiet the input and wait until every reading has come back
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_tracking(input logic [CfgDataBits-1:0] factor,
                              input logic [CfgDataBits-1:0] thresh_word);
    drain_pipeline();
    write_reg(CFG_SMOOTHING_FACTOR, factor);
    write_reg(CFG_TREND_THRESHOLD, thresh_word);
  endtask

  function automatic logic signed [15:0] clamp_temp(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // one shaped run of samples: walks, ramps, steps, plateaus or raw noise
  task automatic send_sequence(input seq_kind_e kind, input int len);
    int slope;
    slope = int'($urandom_range(0, 80)) - 40;
    if ($urandom_range(0, 3) == 0) cur_temp = int'($signed(16'($urandom)));
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_WALK: cur_temp += int'($urandom_range(0, 16)) - 8;
        SEQ_RAMP: cur_temp += slope;
        SEQ_STEP: begin
          if ($urandom_range(0, 9) == 0) cur_temp += int'($urandom_range(0, 4000)) - 2000;
          else cur_temp += int'($urandom_range(0, 2)) - 1;
        end
        SEQ_NOISE: cur_temp = int'($signed(16'($urandom)));
        default: ;
      endcase
      cur_temp = int'(clamp_temp(cur_temp));
      send_sample(16'(cur_temp));
    end
  endtask

  function automatic seq_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return SEQ_WALK;
    if (r < 55) return SEQ_RAMP;
    if (r < 75) return SEQ_STEP;
    if (r < 88) return SEQ_PLATEAU;
    return SEQ_NOISE;
  endfunction

  // receiver: segments of random stall density, one long hold-off on request
  initial begin
    int seg_len;
    int pct;
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        seg_len = $urandom_range(20, 200);
        case ($urandom_range(0, 4))
          0, 1:    pct = 0;
          2:       pct = 20;
          3:       pct = 50;
          default: pct = 85;
        endcase
        repeat (seg_len) begin
          out_stall_i <= ($urandom_range(0, 99) < pct);
          @(posedge clk_i);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int sent;
    int len;
    logic [CfgDataBits-1:0] factor;
    logic [CfgDataBits-1:0] thresh_word;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first sample and full-scale swings at reset settings
    send_sample(16'sd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd16);
    send_sample(-16'sd16);
    // spare register indexes must not disturb anything
    drain_pipeline();
    write_reg(CFG_SPARE_LO, 16'hffff);
    write_reg(CFG_SPARE_HI, 16'(32'($urandom)));
    // full factor, zero threshold (top data bit must be dropped)
    set_tracking(16'hffff, 16'h8000);
    send_sample(16'sd100);
    send_sample(16'sd100);
    send_sample(-16'sd200);
    send_sample(16'sh7fff);
    // zero factor freezes the average
    set_tracking(16'h0000, 16'd4);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    send_sample(16'sd1000);
    // smallest factor, largest threshold
    set_tracking(16'h0001, 16'h7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sd0);
    // half weight, threshold of one count
    set_tracking(16'h8000, 16'd1);
    send_sample(16'sd64);
    send_sample(16'sd64);
    send_sample(-16'sd64);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);

    // random phases, each under its own setting
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin factor = 16'hffff; thresh_word = 16'h0000; end
        1: begin factor = 16'h0001; thresh_word = 16'h7fff; end
        2: begin factor = 16'h0000; thresh_word = 16'd3;    end
        default: begin
          case ($urandom_range(0, 3))
            0:       factor = 16'($urandom_range(1, 65535));
            1:       factor = 16'($urandom_range(1000, 16000));
            default: factor = 16'($urandom_range(2000, 20000));
          endcase
          case ($urandom_range(0, 3))
            0:       thresh_word = 16'($urandom);
            1:       thresh_word = 16'($urandom_range(0, 100)) | 16'h8000;
            default: thresh_word = 16'($urandom_range(1, 64));
          endcase
        end
      endcase
      set_tracking(factor, thresh_word);
      if (phase == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        len = $urandom_range(8, 60);
        send_sequence(pick_kind(), len);
        sent += len;
      end
    end

    // wait for the last readings, then a few quiet cycles
    in_valid_i <= 1'b0;
    for (int w = 0; w < EndWait && pending != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
